FILE: hdl/one_shot_timer_bank_assert.svh
// Assertion macros used by the checker file of the timer bank.
`ifndef ONE_SHOT_TIMER_BANK_ASSERT_SVH
`define ONE_SHOT_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OSTB_ASSERT_SAME(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("one_shot_timer_bank: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OSTB_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("one_shot_timer_bank: assertion failed");

`endif

FILE: hdl/ostb_pkg.sv
// Shared types and constants of the one-shot timer bank.
package ostb_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam int ACTION_W = 3;
  localparam int ID_W     = 3;
  localparam int COUNT_W  = 16;
  localparam int STATE_W  = 2;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_CREATE    = 3'd0;
  localparam action_t ACT_SET_STATE = 3'd1;
  localparam action_t ACT_QUERY     = 3'd2;
  localparam action_t ACT_DELETE    = 3'd3;
  localparam action_t ACT_RESET     = 3'd4;
  localparam action_t ACT_TICK      = 3'd5;

  localparam logic [STATE_W-1:0] STATE_INVALID = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic flush;
  } ostb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic space;
    logic step_ok;
    logic scan_end;
  } ostb_stat_t;

endpackage

FILE: hdl/ostb_datapath.sv
// Slot storage, action logic, tick scan and result register of the timer bank.
module ostb_datapath #(
  parameter int NUM_SLOTS = ostb_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ostb_pkg::ostb_cmd_t           cmd,
  output ostb_pkg::ostb_stat_t          stat,
  input  logic [ostb_pkg::ACTION_W-1:0] action,
  input  logic [ostb_pkg::ID_W-1:0]     timer_id,
  input  logic [ostb_pkg::COUNT_W-1:0]  period,
  input  logic                          run_state,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [ostb_pkg::STATE_W-1:0]  state_read,
  output logic                          fired,
  output logic [ostb_pkg::ID_W-1:0]     fired_timer,
  output logic                          last
);
  import ostb_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // Captured input item.
  action_t            action_q;
  logic [ID_W-1:0]    id_q;
  logic [COUNT_W-1:0] period_q;
  logic               run_q;

  // Slot state.
  logic               slot_exists  [NUM_SLOTS];
  logic               slot_running [NUM_SLOTS];
  logic [COUNT_W-1:0] slot_count   [NUM_SLOTS];
  logic [COUNT_W-1:0] slot_period  [NUM_SLOTS];

  // Tick scan state: slot index and the one expiry held back to learn whether it is last.
  logic [IDX_W-1:0]   idx;
  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;

  logic [IDX_W-1:0]   rd_addr;
  logic               rd_exists;
  logic               rd_running;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] rd_period;
  logic               in_range;
  logic               ex;
  logic [COUNT_W-1:0] cnt_inc;
  logic               live;
  logic               fire;
  logic               space;
  logic               step_ok;

  logic               we;
  logic               w_exists;
  logic               w_running;
  logic [COUNT_W-1:0] w_count;
  logic [COUNT_W-1:0] w_period;

  logic               push;
  logic               res_status;
  logic [STATE_W-1:0] res_state;
  logic               res_fired;
  logic [ID_W-1:0]    res_id;
  logic               res_last;

  assign rd_addr    = cmd.scan ? idx : IDX_W'(id_q);
  assign rd_exists  = slot_exists[rd_addr];
  assign rd_running = slot_running[rd_addr];
  assign rd_count   = slot_count[rd_addr];
  assign rd_period  = slot_period[rd_addr];

  assign in_range = (32'(id_q) < 32'(NUM_SLOTS));
  assign ex       = in_range && rd_exists;
  assign cnt_inc  = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);
  assign live     = rd_exists && rd_running;
  assign fire     = live && (cnt_inc >= rd_period);
  assign space    = !out_valid || out_ready;
  assign step_ok  = !(fire && pend_valid && !space);

  assign stat.is_tick  = (action_q == ACT_TICK);
  assign stat.space    = space;
  assign stat.step_ok  = step_ok;
  assign stat.scan_end = (idx == LAST_IDX);

  always_comb begin
    we         = 1'b0;
    w_exists   = rd_exists;
    w_running  = rd_running;
    w_count    = rd_count;
    w_period   = rd_period;
    push       = 1'b0;
    res_status = 1'b1;
    res_state  = '0;
    res_fired  = 1'b0;
    res_id     = '0;
    res_last   = 1'b1;

    if (cmd.exec && space) begin
      push = 1'b1;
      unique case (action_q)
        ACT_CREATE: begin
          res_status = !in_range;
          if (in_range) begin
            we        = 1'b1;
            w_exists  = 1'b1;
            w_running = run_q;
            w_count   = '0;
            w_period  = period_q;
          end
        end
        ACT_SET_STATE: begin
          res_status = !ex;
          if (ex) begin
            we        = 1'b1;
            w_running = run_q;
          end
        end
        ACT_QUERY: begin
          res_status = !ex;
          res_state  = ex ? {1'b0, rd_running} : STATE_INVALID;
        end
        ACT_DELETE: begin
          res_status = !ex;
          if (ex) begin
            we        = 1'b1;
            w_exists  = 1'b0;
            w_running = 1'b0;
            w_count   = '0;
          end
        end
        ACT_RESET: begin
          res_status = !ex;
          if (ex) begin
            we        = 1'b1;
            w_running = run_q;
            w_count   = '0;
          end
        end
        default: begin
          res_status = 1'b1;
        end
      endcase
    end

    if (cmd.scan && step_ok && live) begin
      we        = 1'b1;
      w_count   = cnt_inc;
      w_running = !fire;
    end

    // A new expiry releases the held one, which is then known not to be last.
    if (cmd.scan && fire && pend_valid && space) begin
      push       = 1'b1;
      res_status = 1'b0;
      res_fired  = 1'b1;
      res_id     = pend_id;
      res_last   = 1'b0;
    end

    if (cmd.flush && space) begin
      push       = 1'b1;
      res_status = 1'b0;
      res_fired  = pend_valid;
      res_id     = pend_valid ? pend_id : '0;
      res_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_exists[i]  <= 1'b0;
        slot_running[i] <= 1'b0;
      end
    end else if (we) begin
      slot_exists[rd_addr]  <= w_exists;
      slot_running[rd_addr] <= w_running;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_count[rd_addr]  <= w_count;
      slot_period[rd_addr] <= w_period;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action;
      id_q     <= timer_id;
      period_q <= period;
      run_q    <= run_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.capture) begin
      idx        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.scan && step_ok) begin
      idx <= IDX_W'(idx + IDX_W'(1));
      if (fire) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && step_ok && fire) begin
      pend_id <= ID_W'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status      <= res_status;
      state_read  <= res_state;
      fired       <= res_fired;
      fired_timer <= res_id;
      last        <= res_last;
    end
  end

endmodule

FILE: hdl/ostb_controller.sv
// Sequencing state machine of the timer bank.
module ostb_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output ostb_pkg::ostb_cmd_t  cmd,
  input  ostb_pkg::ostb_stat_t stat
);
  import ostb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = in_valid && in_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_tick) begin
          state_next = ST_SCAN;
        end else begin
          cmd.exec = 1'b1;
          if (stat.space) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.step_ok && stat.scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (stat.space) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

FILE: hdl/one_shot_timer_bank.sv
// Top level of the one-shot timer bank: controller and datapath.
//
// The block holds NUM_SLOTS one-shot timer slots, each with an exists mark, a run
// mark, a 16-bit count and a 16-bit period. Commands arrive on the input channel
// (in_valid/in_ready) as one transfer of action, timer_id, period and run_state.
// Results leave on the output channel (out_valid/out_ready), one transfer each.
// Create, set state, query, delete, reset and unknown actions give one result,
// which is loaded into the result register from the exec state once it has space.
// A tick walks the slots through the shared slot read port, one per cycle while
// it does not pause; it gives one result per expiring slot in ascending order,
// the final one marked by last, or one result with fired low if none expire.
// One command is worked on at a time; in_ready returns when its last result
// has been loaded into the output register, so a new command may be taken while
// that result still waits for the receiver.
// When the receiver stalls, the result register holds, and a tick pauses at the
// next expiring slot while an expiry is held, until the waiting result is taken.
// Synchronous reset clears every exists and run mark, empties the result
// register and returns the controller to idle; in_ready rises the cycle after.
module one_shot_timer_bank #(
  parameter int NUM_SLOTS = ostb_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ostb_pkg::ACTION_W-1:0] action,
  input  logic [ostb_pkg::ID_W-1:0]     timer_id,
  input  logic [ostb_pkg::COUNT_W-1:0]  period,
  input  logic                          run_state,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [ostb_pkg::STATE_W-1:0]  state_read,
  output logic                          fired,
  output logic [ostb_pkg::ID_W-1:0]     fired_timer,
  output logic                          last
);
  import ostb_pkg::*;

  ostb_cmd_t  cmd;
  ostb_stat_t stat;

  ostb_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ostb_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .timer_id    (timer_id),
    .period      (period),
    .run_state   (run_state),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .state_read  (state_read),
    .fired       (fired),
    .fired_timer (fired_timer),
    .last        (last)
  );

endmodule

FILE: hdl/ostb_checker.sv
// Port-level assertions of the timer bank and their bind to the top level.
`include "one_shot_timer_bank_assert.svh"

module ostb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          status,
  input logic [ostb_pkg::STATE_W-1:0]  state_read,
  input logic                          fired,
  input logic [ostb_pkg::ID_W-1:0]     fired_timer,
  input logic                          last
);
  import ostb_pkg::*;

  // All result fields in one vector, so that a stall can be checked as a whole.
  logic [STATE_W+ID_W+2:0] out_fields;

  assign out_fields = {status, state_read, fired, fired_timer, last};

  // A stalled result holds until its transfer.
  `OSTB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_fields))

  // Only expiry results can be followed by more results of the same command.
  `OSTB_ASSERT_SAME(a_nofire_last, clk, rst, out_valid && !fired, last)

  // An expiry result always reports success and no query answer.
  `OSTB_ASSERT_SAME(a_fire_clean, clk, rst, out_valid && fired, !status && (state_read == 2'd0))

  // A query of a missing slot must also fail.
  `OSTB_ASSERT_SAME(a_invalid_fail, clk, rst, out_valid && (state_read == STATE_INVALID), status)

endmodule

bind one_shot_timer_bank ostb_checker u_ostb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .state_read  (state_read),
  .fired       (fired),
  .fired_timer (fired_timer),
  .last        (last)
);
